// ===== rtl/assert_macros.svh =====
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/ivti_pkg.sv =====
// shared constants for the vlan tag inserter
package ivti_pkg;
  localparam int unsigned RuleSlotsDef = 16;
  localparam int unsigned HoldLen = 46;
  localparam logic [15:0] EthIpv4 = 16'h0800;
  localparam logic [7:0] TpidHigh = 8'h81;
  localparam logic [7:0] TpidLow = 8'h00;
  localparam logic [0:0] OpByte = 1'b0;
  localparam logic [0:0] OpLoad = 1'b1;
  localparam logic [0:0] RegRuleCount = 1'b0;
endpackage

// ===== rtl/ipv4_range_vlan_tag_inserter.sv =====
// top level: collects header, searches rules, emits tagged frame
// sequence: after byte 46 the ethertype and address bytes are read from the hold memory,
// then the rule search compares one entry per cycle, up to rule_count entries (count capped at
// the slot count), then 50 bytes (46 held, 4 tag) are sent one per cycle unless stalled.
// throughput: one byte per cycle while collecting, or while streaming and not stalled; a
// stream byte is output in the cycle after it is accepted. reset is asynchronous active low
`include "assert_macros.svh"
module ipv4_range_vlan_tag_inserter #(
  parameter int unsigned RuleSlots = ivti_pkg::RuleSlotsDef,
  parameter int unsigned IdxW = (RuleSlots > 1) ? $clog2(RuleSlots) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic [3:0]  rule_index_i,
  input  logic [31:0] rule_ip_low_i,
  input  logic [31:0] rule_ip_high_i,
  input  logic [11:0] rule_vid_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [0:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  // state and rule_count; memories are not cleared
  typedef enum logic [2:0] {
    S_IDLE, S_EA, S_EB, S_ADDR, S_SRCH, S_EMIT, S_STRM, S_DROP
  } state_e;

  state_e      state_q;
  logic [5:0]  pos_q;
  logic [4:0]  rule_count_q;
  logic [5:0]  rd_q;      // hold read address
  logic [5:0]  k_q;       // emitted/read step counter
  logic [15:0] eth_q;
  logic [31:0] addr_q;
  logic [8:0]  ri_q;      // rule index issued
  logic        rv_q;      // rule read pending
  logic        last_q;
  logic [11:0] vid_q;
  logic [7:0]  ob_q;
  logic        ol_q;
  logic        ov_q;
  logic [4:0]  ncap;

  logic        acc, cfg_we;
  logic        hwe;
  logic [5:0]  hraddr;
  logic [7:0]  hrdata;
  logic [75:0] rdata;
  logic [IdxW-1:0] rraddr;
  logic [IdxW-1:0] slot_map [16];

  assign ncap = (32'(rule_count_q) > RuleSlots) ? 5'(RuleSlots) : rule_count_q;
  assign pready_o = 1'b1;
  assign prdata_o = {27'd0, rule_count_q};
  assign cfg_we = psel_i & penable_i & pwrite_i & (paddr_i == ivti_pkg::RegRuleCount);
  assign in_stall_o = !((state_q == S_IDLE) || (state_q == S_DROP) ||
                        (state_q == S_STRM && !(ov_q && out_stall_i)));
  assign acc = in_valid_i & ~in_stall_o;
  assign out_valid_o = ov_q;
  assign out_byte_o = ob_q;
  assign out_last_o = ol_q;
  assign hwe = acc && operation_i == ivti_pkg::OpByte && state_q == S_IDLE;
  assign rraddr = IdxW'(ri_q);

  logic out_free;
  assign out_free = !ov_q || !out_stall_i;

  // rule slot for each index, wrapped at the slot count
  always_comb begin
    for (int i = 0; i < 16; i++) slot_map[i] = IdxW'(i % RuleSlots);
  end

  // hold read address runs one byte ahead of the replay
  always_comb begin
    hraddr = rd_q;
    if (state_q == S_SRCH) hraddr = '0;
    else if (state_q == S_EMIT && out_free && k_q != 6'd11 && k_q != 6'd12 &&
             k_q != 6'd13 && k_q != 6'd14 && k_q != 6'd49)
      hraddr = rd_q + 6'd1;
  end

  ivti_hold u_hold (
    .clk_i(clk_i), .we_i(hwe), .waddr_i(pos_q), .wdata_i(in_byte_i),
    .raddr_i(hraddr), .rdata_o(hrdata)
  );

  ivti_rules #(.RuleSlots(RuleSlots), .IdxW(IdxW)) u_rules (
    .clk_i(clk_i),
    .we_i(acc && operation_i == ivti_pkg::OpLoad),
    .waddr_i(slot_map[rule_index_i]),
    .wdata_i({rule_ip_low_i, rule_ip_high_i, rule_vid_i}),
    .raddr_i(rraddr), .rdata_o(rdata)
  );

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pos_q <= '0; rule_count_q <= '0; ov_q <= 1'b0;
      rv_q <= 1'b0; rd_q <= '0; k_q <= '0; ri_q <= '0;
      last_q <= 1'b0; eth_q <= '0; addr_q <= '0; vid_q <= '0;
      ob_q <= '0; ol_q <= 1'b0;
    end else begin
      if (cfg_we) rule_count_q <= pwdata_i[4:0];
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (acc && operation_i == ivti_pkg::OpByte) begin
            if (pos_q == 6'(ivti_pkg::HoldLen - 1)) begin
              pos_q <= '0; last_q <= in_last_i; rd_q <= 6'd12; state_q <= S_EA;
            end else pos_q <= in_last_i ? 6'd0 : pos_q + 6'd1;
          end
        end
        // read ethertype and address bytes, one per cycle
        S_EA: begin rd_q <= 6'd13; state_q <= S_EB; k_q <= '0; end
        S_EB: begin
          eth_q[15:8] <= hrdata; rd_q <= 6'd30; state_q <= S_ADDR;
        end
        S_ADDR: begin
          if (k_q == 6'd0) eth_q[7:0] <= hrdata;
          else addr_q <= {addr_q[23:0], hrdata};
          if (rd_q < 6'd33) rd_q <= rd_q + 6'd1;
          k_q <= k_q + 6'd1;
          if (k_q == 6'd4) begin
            state_q <= S_SRCH; ri_q <= '0; rv_q <= 1'b0;
          end
        end
        // one rule compared per cycle
        S_SRCH: begin
          rv_q <= (ri_q < 9'(ncap)) && (eth_q == ivti_pkg::EthIpv4);
          ri_q <= ri_q + 9'd1;
          if (rv_q && rdata[75:44] <= addr_q && rdata[43:12] >= addr_q) begin
            vid_q <= rdata[11:0]; state_q <= S_EMIT; rd_q <= '0; k_q <= '0;
          end else if (ri_q > 9'(ncap) || eth_q != ivti_pkg::EthIpv4) begin
            state_q <= last_q ? S_IDLE : S_DROP;
          end
        end
        // replay 50 bytes: 12 mac, 4 tag, 34 held
        S_EMIT: begin
          if (out_free) begin
            ov_q <= 1'b1; ol_q <= 1'b0;
            case (k_q)
              6'd12: ob_q <= ivti_pkg::TpidHigh;
              6'd13: ob_q <= ivti_pkg::TpidLow;
              6'd14: ob_q <= {4'd0, vid_q[11:8]};
              6'd15: ob_q <= vid_q[7:0];
              default: ob_q <= hrdata;
            endcase
            if (k_q == 6'd49) begin
              ol_q <= last_q; state_q <= last_q ? S_IDLE : S_STRM;
            end
            k_q <= k_q + 6'd1;
            if (k_q != 6'd11 && k_q != 6'd12 && k_q != 6'd13 && k_q != 6'd14)
              rd_q <= rd_q + 6'd1;
          end
        end
        S_STRM: begin
          if (acc && operation_i == ivti_pkg::OpByte) begin
            ov_q <= 1'b1; ob_q <= in_byte_i; ol_q <= in_last_i;
            if (in_last_i) state_q <= S_IDLE;
          end
        end
        S_DROP: begin
          if (acc && operation_i == ivti_pkg::OpByte && in_last_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_stall_out_hold, clk_i, rst_ni, (ov_q && out_stall_i) |=> (ov_q && $stable(ob_q)))
  `ASSERT_NEVER(a_pos_range, clk_i, rst_ni, pos_q >= 6'(ivti_pkg::HoldLen))
  `ASSERT_NEVER(a_emit_count, clk_i, rst_ni, state_q == S_EMIT && k_q > 6'd49)
endmodule

// ===== rtl/ivti_rules.sv =====
// rule table memory: one write port, one registered read port
module ivti_rules #(
  parameter int unsigned RuleSlots = ivti_pkg::RuleSlotsDef,
  parameter int unsigned IdxW = (RuleSlots > 1) ? $clog2(RuleSlots) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [75:0]     wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [75:0]     rdata_o
);
  logic [75:0] mem [RuleSlots];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/ivti_hold.sv =====
// header hold buffer memory with registered read
module ivti_hold (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [5:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic [5:0] raddr_i,
  output logic [7:0] rdata_o
);
  logic [7:0] mem [ivti_pkg::HoldLen];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
